// File: design/ast_pkg.sv
// Package for the assembly source tokenizer: transaction structs, token kinds,
// error codes, character constants and the keyword table.
// No dependencies; used by assembly_source_tokenizer_top.
package ast_pkg;

   localparam int POS_BITS_DEFAULT = 16;

   typedef struct packed {
      logic       func;
      logic [7:0] source_byte;
   } req_type;

   typedef struct packed {
      logic [5:0]  token_kind;
      logic [1:0]  error_code;
      logic [15:0] token_start;
      logic [15:0] token_end;
      logic        last_of_run;
   } rsp_type;

   // Input function codes.
   localparam logic FUNC_BYTE = 1'b0;
   localparam logic FUNC_END  = 1'b1;

   // Token kinds.
   localparam logic [5:0] KIND_EOF      = 6'd0;
   localparam logic [5:0] KIND_COLON    = 6'd1;
   localparam logic [5:0] KIND_COMMA    = 6'd2;
   localparam logic [5:0] KIND_PLUS     = 6'd3;
   localparam logic [5:0] KIND_LBRACKET = 6'd4;
   localparam logic [5:0] KIND_RBRACKET = 6'd5;
   localparam logic [5:0] KIND_STRING   = 6'd6;
   localparam logic [5:0] KIND_IDENT    = 6'd7;
   localparam logic [5:0] KIND_DEC      = 6'd8;
   localparam logic [5:0] KIND_KEYWORD0 = 6'd12;
   localparam logic [5:0] KIND_ERROR    = 6'd43;

   // Error codes.
   localparam logic [1:0] ERR_NONE       = 2'd0;
   localparam logic [1:0] ERR_INVALID    = 2'd1;
   localparam logic [1:0] ERR_INCOMPLETE = 2'd2;
   localparam logic [1:0] ERR_UNEXPECTED = 2'd3;

   // Number bases; the numeric token kind is KIND_DEC plus the base code.
   localparam logic [1:0] BASE_DEC = 2'd0;
   localparam logic [1:0] BASE_HEX = 2'd1;
   localparam logic [1:0] BASE_BIN = 2'd2;
   localparam logic [1:0] BASE_OCT = 2'd3;

   // Characters.
   localparam logic [7:0] CH_SPACE    = 8'h20;
   localparam logic [7:0] CH_NEWLINE  = 8'h0A;
   localparam logic [7:0] CH_SEMI     = 8'h3B;
   localparam logic [7:0] CH_COLON    = 8'h3A;
   localparam logic [7:0] CH_COMMA    = 8'h2C;
   localparam logic [7:0] CH_PLUS     = 8'h2B;
   localparam logic [7:0] CH_LBRACKET = 8'h5B;
   localparam logic [7:0] CH_RBRACKET = 8'h5D;
   localparam logic [7:0] CH_QUOTE    = 8'h22;
   localparam logic [7:0] CH_UNDER    = 8'h5F;
   localparam logic [7:0] CH_LOW_X    = 8'h78;
   localparam logic [7:0] CH_LOW_B    = 8'h62;

   // Keywords, left-justified and zero padded to four characters.
   localparam int KW_COUNT = 31;
   localparam logic [31:0] KW_NAME [KW_COUNT] = '{
      {"SET", 8'h00}, {"ADD", 8'h00}, {"SUB", 8'h00}, {"MUL", 8'h00},
      {"DIV", 8'h00}, {"MOD", 8'h00}, {"SHL", 8'h00}, {"SHR", 8'h00},
      {"AND", 8'h00}, {"BOR", 8'h00}, {"XOR", 8'h00}, {"IFE", 8'h00},
      {"IFN", 8'h00}, {"IFG", 8'h00}, {"IFB", 8'h00}, {"JSR", 8'h00},
      {"DAT", 8'h00}, "PUSH", "PEEK", {"POP", 8'h00},
      {"SP", 16'h0000}, {"PC", 16'h0000},
      {"O", 24'h0}, {"A", 24'h0}, {"B", 24'h0}, {"C", 24'h0}, {"X", 24'h0},
      {"Y", 24'h0}, {"Z", 24'h0}, {"I", 24'h0}, {"J", 24'h0}
   };
   localparam logic [2:0] KW_LEN [KW_COUNT] = '{
      3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3,
      3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd4, 3'd4, 3'd3, 3'd2, 3'd2,
      3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1
   };

endpackage

// File: design/assembly_source_tokenizer_top.sv
// Top level of the assembly source tokenizer: scanner state machine, keyword
// match and result queue in one module.
// Depends on ast_pkg for the transaction structs, codes and keyword table.
//
// Usage: source bytes arrive on the req_ channel, one transaction per byte,
// with func set to FUNC_BYTE; a transaction with func set to FUNC_END closes
// the source, flushes any pending token, emits an end-of-source token and
// restarts positions at zero. Tokens and error items leave on the rsp_
// channel, one per transaction; one request causes zero, one or two results,
// and last_of_run marks the final result of each request.
// A request is taken into an input register, from which the scanner handles
// it and writes its results into a four-entry result queue whose head drives
// rsp_data.
// Throughput is one request per cycle while the receiver keeps up. req_stall
// rises only when the queue holds more than two results, so a request with
// two results is absorbed as long as the receiver drains one per cycle.
// When the receiver stalls, the queue fills and the input register then
// holds its transaction until room for two results opens again.
// Reset empties the queue and the input register and returns the scanner to
// the between-tokens state at byte position zero.
module assembly_source_tokenizer_top #(
   parameter int POSITION_BITS = ast_pkg::POS_BITS_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  ast_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output ast_pkg::rsp_type rsp_data
);
   import ast_pkg::*;

   localparam int QDEPTH = 4;
   localparam int QAW = $clog2(QDEPTH);

   typedef enum logic [2:0] {
      MODE_IDLE, MODE_COMMENT, MODE_STRING, MODE_IDENT,
      MODE_ZERO, MODE_PREFIX, MODE_DIGITS, MODE_DEAD
   } mode_type;

   // Input register.
   logic    in_vld_ff;
   req_type in_data_ff;

   // Scanner state.
   mode_type               mode_ff, mode_in;
   logic [POSITION_BITS-1:0] pos_ff, pos_in;
   logic [POSITION_BITS-1:0] tb_ff, tb_in;
   logic [6:0]             chars_ff [4];
   logic [6:0]             chars_in [4];
   logic [2:0]             len_ff, len_in;
   logic [1:0]             base_ff, base_in;

   // Result queue.
   rsp_type        q_mem_ff [QDEPTH];
   logic [QAW-1:0] q_wr_ff, q_rd_ff;
   logic [QAW:0]   q_cnt_ff;

   logic    advance;
   logic    pop;
   rsp_type res [2];
   logic [1:0] res_cnt;

   logic [7:0] c;
   logic [6:0] c_up;
   logic [15:0] p16, p1_16, tb16, tb1_16;
   logic [POSITION_BITS-1:0] p_plus1;
   logic [5:0] ident_kind;

   // Outcome of handling the byte as if between tokens.
   mode_type                 idle_mode;
   logic                     idle_emit;
   rsp_type                  idle_res;
   logic                     idle_tb_set;
   logic [POSITION_BITS-1:0] idle_tb;
   logic                     idle_ident;

   function automatic logic is_alpha(input logic [7:0] ch);
      return (ch >= "a" && ch <= "z") || (ch >= "A" && ch <= "Z");
   endfunction

   function automatic logic is_dec(input logic [7:0] ch);
      return ch >= "0" && ch <= "9";
   endfunction

   function automatic logic is_word(input logic [7:0] ch);
      return is_alpha(ch) || is_dec(ch) || ch == CH_UNDER;
   endfunction

   function automatic logic is_digit_of(input logic [7:0] ch, input logic [1:0] base);
      logic r;
      unique case (base)
         BASE_HEX: r = is_dec(ch) || (ch >= "a" && ch <= "f") || (ch >= "A" && ch <= "F");
         BASE_BIN: r = ch == "0" || ch == "1";
         BASE_OCT: r = ch >= "0" && ch <= "7";
         default:  r = is_dec(ch);
      endcase
      return r;
   endfunction

   function automatic rsp_type mk(input logic [5:0] kind, input logic [1:0] code,
                                  input logic [15:0] s, input logic [15:0] e);
      rsp_type r;
      r.token_kind  = kind;
      r.error_code  = code;
      r.token_start = s;
      r.token_end   = e;
      r.last_of_run = 1'b0;
      return r;
   endfunction

   assign advance   = in_vld_ff && (q_cnt_ff <= (QAW+1)'(QDEPTH - 2));
   assign req_stall = in_vld_ff && !advance;
   assign rsp_valid = q_cnt_ff != '0;
   assign rsp_data  = q_mem_ff[q_rd_ff];
   assign pop       = rsp_valid && !rsp_stall;

   assign c       = in_data_ff.source_byte;
   assign c_up    = (c >= "a" && c <= "z") ? 7'(c - 8'd32) : c[6:0];
   assign p_plus1 = pos_ff + 1'b1;
   assign p16     = 16'(pos_ff);
   assign p1_16   = 16'({1'b0, pos_ff} + (POSITION_BITS+1)'(1));
   assign tb16    = 16'(tb_ff);
   assign tb1_16  = 16'({1'b0, tb_ff} + (POSITION_BITS+1)'(1));

   // Keyword lookup over the stored identifier; all compares run in parallel.
   always_comb begin
      ident_kind = KIND_IDENT;
      for (int k = KW_COUNT - 1; k >= 0; k--) begin
         if (len_ff >= 3'd1 && len_ff <= 3'd4 && KW_LEN[k] == len_ff &&
             chars_ff[0] == KW_NAME[k][30:24] && chars_ff[1] == KW_NAME[k][22:16] &&
             chars_ff[2] == KW_NAME[k][14:8] && chars_ff[3] == KW_NAME[k][6:0]) begin
            ident_kind = KIND_KEYWORD0 + 6'(k);
         end
      end
   end

   always_comb begin
      idle_mode   = MODE_IDLE;
      idle_emit   = 1'b0;
      idle_res    = mk(KIND_COLON, ERR_NONE, p16, p1_16);
      idle_tb_set = 1'b0;
      idle_tb     = pos_ff;
      idle_ident  = 1'b0;
      if (c > CH_SPACE) begin
         priority if (c == CH_SEMI) begin
            idle_mode = MODE_COMMENT;
         end else if (c == CH_COLON) begin
            idle_emit = 1'b1;
         end else if (c == CH_COMMA) begin
            idle_emit = 1'b1;
            idle_res.token_kind = KIND_COMMA;
         end else if (c == CH_PLUS) begin
            idle_emit = 1'b1;
            idle_res.token_kind = KIND_PLUS;
         end else if (c == CH_LBRACKET) begin
            idle_emit = 1'b1;
            idle_res.token_kind = KIND_LBRACKET;
         end else if (c == CH_RBRACKET) begin
            idle_emit = 1'b1;
            idle_res.token_kind = KIND_RBRACKET;
         end else if (c == CH_QUOTE) begin
            idle_mode   = MODE_STRING;
            idle_tb_set = 1'b1;
            idle_tb     = p_plus1;
         end else if (is_alpha(c) || c == CH_UNDER) begin
            idle_mode   = MODE_IDENT;
            idle_tb_set = 1'b1;
            idle_ident  = 1'b1;
         end else if (c == "0") begin
            idle_mode   = MODE_ZERO;
            idle_tb_set = 1'b1;
         end else if (is_dec(c)) begin
            idle_mode   = MODE_DIGITS;
            idle_tb_set = 1'b1;
         end else begin
            idle_mode = MODE_DEAD;
            idle_emit = 1'b1;
            idle_res  = mk(KIND_ERROR, ERR_INVALID, p16, p16);
         end
      end
   end

   // Scanner: next state and up to two results for the registered request.
   always_comb begin
      logic take_idle;
      take_idle = 1'b0;
      mode_in  = mode_ff;
      pos_in   = pos_ff;
      tb_in    = tb_ff;
      chars_in = chars_ff;
      len_in   = len_ff;
      base_in  = base_ff;
      res[0]   = mk(KIND_EOF, ERR_NONE, p16, p16);
      res[1]   = mk(KIND_EOF, ERR_NONE, p16, p16);
      res_cnt  = 2'd0;
      if (in_data_ff.func == FUNC_END) begin
         unique case (mode_ff)
            MODE_STRING: begin
               res[0] = mk(KIND_STRING, ERR_NONE, tb16, p16);
               res_cnt = 2'd1;
            end
            MODE_IDENT: begin
               res[0] = mk(ident_kind, ERR_NONE, tb16, p16);
               res_cnt = 2'd1;
            end
            MODE_ZERO: begin
               res[0] = mk(KIND_DEC, ERR_NONE, tb16, tb1_16);
               res_cnt = 2'd1;
            end
            MODE_PREFIX: begin
               res[0] = mk(KIND_ERROR, ERR_INCOMPLETE, tb16, tb16);
               res_cnt = 2'd1;
            end
            MODE_DIGITS: begin
               res[0] = mk(KIND_DEC + 6'(base_ff), ERR_NONE, tb16, p16);
               res_cnt = 2'd1;
            end
            MODE_IDLE, MODE_COMMENT, MODE_DEAD: begin
            end
         endcase
         res[res_cnt[0]] = mk(KIND_EOF, ERR_NONE, p16, p16);
         res_cnt  = res_cnt + 2'd1;
         mode_in  = MODE_IDLE;
         pos_in   = '0;
         tb_in    = '0;
         chars_in = '{default: '0};
         len_in   = '0;
         base_in  = BASE_DEC;
      end else begin
         unique case (mode_ff)
            MODE_COMMENT: begin
               if (c == CH_NEWLINE) mode_in = MODE_IDLE;
            end
            MODE_STRING: begin
               if (c == CH_QUOTE) begin
                  res[0] = mk(KIND_STRING, ERR_NONE, tb16, p16);
                  res_cnt = 2'd1;
                  mode_in = MODE_IDLE;
               end
            end
            MODE_IDENT: begin
               if (is_word(c)) begin
                  if (len_ff < 3'd4) chars_in[len_ff[1:0]] = c_up;
                  if (len_ff < 3'd7) len_in = len_ff + 3'd1;
               end else begin
                  res[0] = mk(ident_kind, ERR_NONE, tb16, p16);
                  res_cnt = 2'd1;
                  take_idle = 1'b1;
               end
            end
            MODE_ZERO: begin
               if (c == CH_LOW_X || c == CH_LOW_B) begin
                  mode_in = MODE_PREFIX;
                  base_in = (c == CH_LOW_X) ? BASE_HEX : BASE_BIN;
               end else if (is_digit_of(c, BASE_OCT)) begin
                  mode_in = MODE_DIGITS;
                  base_in = BASE_OCT;
                  tb_in   = pos_ff;
               end else begin
                  res[0] = mk(KIND_DEC, ERR_NONE, tb16, tb1_16);
                  res_cnt = 2'd1;
                  take_idle = 1'b1;
               end
            end
            MODE_PREFIX: begin
               if (is_digit_of(c, base_ff)) begin
                  mode_in = MODE_DIGITS;
                  tb_in   = pos_ff;
               end else begin
                  res[0] = mk(KIND_ERROR, ERR_INCOMPLETE, tb16, tb16);
                  res_cnt = 2'd1;
                  mode_in = MODE_DEAD;
               end
            end
            MODE_DIGITS: begin
               if (is_digit_of(c, base_ff)) begin
                  mode_in = MODE_DIGITS;
               end else if (is_word(c)) begin
                  res[0] = mk(KIND_ERROR, ERR_UNEXPECTED, p16, p16);
                  res_cnt = 2'd1;
                  mode_in = MODE_DEAD;
               end else begin
                  res[0] = mk(KIND_DEC + 6'(base_ff), ERR_NONE, tb16, p16);
                  res_cnt = 2'd1;
                  take_idle = 1'b1;
               end
            end
            MODE_DEAD: begin
            end
            MODE_IDLE: begin
               take_idle = 1'b1;
            end
         endcase
         if (take_idle) begin
            mode_in = idle_mode;
            if (idle_emit) begin
               res[res_cnt[0]] = idle_res;
               res_cnt = res_cnt + 2'd1;
            end
            if (idle_tb_set) tb_in = idle_tb;
            if (idle_mode == MODE_DIGITS) base_in = BASE_DEC;
            if (idle_ident) begin
               chars_in = '{c_up, 7'd0, 7'd0, 7'd0};
               len_in   = 3'd1;
            end
         end
         pos_in = p_plus1;
      end
      if (res_cnt == 2'd2) begin
         res[1].last_of_run = 1'b1;
      end else begin
         res[0].last_of_run = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
         mode_ff   <= MODE_IDLE;
         pos_ff    <= '0;
         tb_ff     <= '0;
         chars_ff  <= '{default: '0};
         len_ff    <= '0;
         base_ff   <= BASE_DEC;
         q_wr_ff   <= '0;
         q_rd_ff   <= '0;
         q_cnt_ff  <= '0;
      end else begin
         if (!req_stall) begin
            in_vld_ff <= req_valid;
         end
         if (advance) begin
            mode_ff  <= mode_in;
            pos_ff   <= pos_in;
            tb_ff    <= tb_in;
            chars_ff <= chars_in;
            len_ff   <= len_in;
            base_ff  <= base_in;
            q_wr_ff  <= q_wr_ff + QAW'(res_cnt);
         end
         if (pop) begin
            q_rd_ff <= q_rd_ff + 1'b1;
         end
         q_cnt_ff <= q_cnt_ff + (advance ? (QAW+1)'(res_cnt) : '0) - (QAW+1)'(pop);
      end
   end

   // Payload registers: input data and queue entries need no reset.
   always_ff @(posedge clock) begin
      if (!req_stall) begin
         in_data_ff <= req_data;
      end
      if (advance && res_cnt != 2'd0) begin
         q_mem_ff[q_wr_ff] <= res[0];
      end
      if (advance && res_cnt == 2'd2) begin
         q_mem_ff[q_wr_ff + 1'b1] <= res[1];
      end
   end

endmodule
